>>> sv/ates_pkg.sv
// shared types and character codes for the text screen terminal
package ates_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP
   } ates_state_type;

   localparam logic [7:0] CH_BEL      = 8'h07;
   localparam logic [7:0] CH_BS       = 8'h08;
   localparam logic [7:0] CH_LF       = 8'h0a;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_SEMI     = 8'h3b;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_UPPER_M  = 8'h4d;
   localparam logic [7:0] FINAL_LOW   = 8'h40;
   localparam logic [7:0] FINAL_HIGH  = 8'h7e;
   localparam logic [7:0] NUM_MAX     = 8'hff;

   localparam logic [7:0] CSI_UP      = 8'h41;
   localparam logic [7:0] CSI_DOWN    = 8'h42;
   localparam logic [7:0] CSI_RIGHT   = 8'h43;
   localparam logic [7:0] CSI_LEFT    = 8'h44;
   localparam logic [7:0] CSI_POS     = 8'h48;
   localparam logic [7:0] CSI_CLEAR   = 8'h4a;
   localparam logic [7:0] CSI_ERASE   = 8'h4b;
   localparam logic [7:0] CSI_POS_ALT = 8'h66;

endpackage

>>> sv/ates_if.sv
// request and response channel interfaces of the text screen terminal
interface ates_req_if #(
   parameter int ROW_W = 5,
   parameter int COL_W = 7
);
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [7:0]       byte_in;
   logic [ROW_W-1:0] read_row;
   logic [COL_W-1:0] read_col;

   modport source (output valid, cmd, byte_in, read_row, read_col, input ready);
   modport sink (input valid, cmd, byte_in, read_row, read_col, output ready);
endinterface

interface ates_rsp_if #(
   parameter int ROW_W = 5,
   parameter int COL_W = 7
);
   logic             valid;
   logic             ready;
   logic [7:0]       cell_value;
   logic [COL_W-1:0] column_now;
   logic [ROW_W-1:0] row_now;
   logic             escape_pending;

   modport source (output valid, cell_value, column_now, row_now, escape_pending,
                   input ready);
   modport sink (input valid, cell_value, column_now, row_now, escape_pending,
                 output ready);
endinterface

>>> sv/ansi_escape_text_screen.sv
// text screen terminal: character store, cursor and escape sequence decoder
//
// req_ch takes one word per handshake: cmd 0 feeds byte_in to the terminal,
// cmd 1 reads the cell at read_row/read_col. rsp_ch returns one word per
// request: the cell read (0 for feeds or cells off the screen), the cursor
// column and row after the step, and whether an escape sequence is open.
// the screen lives in one synchronous ram with a single write port.
// timing: a feed writes its cell at the accept edge and queues its word at
// once; a read word is queued in the cycle after the accept, from the
// registered output of the ram. ESC [ J sweeps the whole ram, one cell a
// cycle; ESC [ K sweeps from the cursor to the end of its line. no request
// is taken during a sweep.
// reset: cursor home, decoder idle, then a clearing pass writes spaces over
// all SCREEN_ROWS*SCREEN_COLS cells before req_ch.ready rises.
// stalls: responses wait in a two-word queue; while the queue is full
// req_ch.ready stays low, so nothing is lost when the receiver stalls.
module ansi_escape_text_screen #(
   parameter int SCREEN_ROWS  = 24,
   parameter int SCREEN_COLS  = 80,
   parameter int ESCAPE_STORE = 63
) (
   input  logic       clock,
   input  logic       reset,
   ates_req_if.sink   req_ch,
   ates_rsp_if.source rsp_ch
);

   localparam int ROW_W  = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int COL_W  = $clog2(SCREEN_COLS + 1);
   localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int EC_W   = $clog2(ESCAPE_STORE + 1);

   localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLS);
   localparam logic [ADDR_W-1:0] COLS_M1_A  = ADDR_W'(SCREEN_COLS - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
   localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLS - 1);
   localparam logic [COL_W-1:0]  COLS_C     = COL_W'(SCREEN_COLS);
   localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [8:0]        COLS_9     = 9'(SCREEN_COLS);
   localparam logic [8:0]        ROWS_9     = 9'(SCREEN_ROWS);
   localparam logic [EC_W-1:0]   STORE_FULL = EC_W'(ESCAPE_STORE);

   typedef struct packed {
      logic [7:0]       cell_value;
      logic [COL_W-1:0] column_now;
      logic [ROW_W-1:0] row_now;
      logic             escape_pending;
   } result_type;

   // control state
   ates_pkg::ates_state_type state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic              in_esc_ff, in_esc_in;
   logic [EC_W-1:0]   esc_cnt_ff, esc_cnt_in;
   logic [7:0]        first_ff, first_in;
   logic [7:0]        second_ff, second_in;
   logic [1:0]        num_idx_ff, num_idx_in;
   logic              spoiled_ff, spoiled_in;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_end_ff, sweep_end_in;
   logic              oob_ff, oob_in;

   // response queue: head drives rsp_ch, tail holds a second word
   result_type head_ff, head_in, tail_ff, tail_in;
   logic       head_v_ff, head_v_in, tail_v_ff, tail_v_in;

   // screen ram ports
   logic [7:0]        screen_mem [CELLS];
   logic [7:0]        rdata_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]        mem_wdata;

   logic       req_accept, rsp_take, enq;
   result_type enq_word;

   assign req_ch.ready = (state_ff == ates_pkg::ST_IDLE) && !tail_v_ff;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_take     = head_v_ff && rsp_ch.ready;

   assign rsp_ch.valid          = head_v_ff;
   assign rsp_ch.cell_value     = head_ff.cell_value;
   assign rsp_ch.column_now     = head_ff.column_now;
   assign rsp_ch.row_now        = head_ff.row_now;
   assign rsp_ch.escape_pending = head_ff.escape_pending;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= screen_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ates_pkg::ST_SWEEP;
         col_ff        <= '0;
         line_ff       <= '0;
         in_esc_ff     <= 1'b0;
         esc_cnt_ff    <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         num_idx_ff    <= '0;
         spoiled_ff    <= 1'b0;
         sweep_addr_ff <= '0;
         sweep_end_ff  <= LAST_CELL;
         head_v_ff     <= 1'b0;
         tail_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         line_ff       <= line_in;
         in_esc_ff     <= in_esc_in;
         esc_cnt_ff    <= esc_cnt_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         num_idx_ff    <= num_idx_in;
         spoiled_ff    <= spoiled_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_end_ff  <= sweep_end_in;
         head_v_ff     <= head_v_in;
         tail_v_ff     <= tail_v_in;
      end
      oob_ff  <= oob_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   always_comb begin
      logic [7:0]        b;
      logic              spoil_now;
      logic [7:0]        num_sel;
      logic [11:0]       acc;
      logic [7:0]        num_sat;
      logic [7:0]        n;
      logic [8:0]        sum;
      logic [ADDR_W-1:0] row_base;

      state_in      = state_ff;
      col_in        = col_ff;
      line_in       = line_ff;
      in_esc_in     = in_esc_ff;
      esc_cnt_in    = esc_cnt_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      num_idx_in    = num_idx_ff;
      spoiled_in    = spoiled_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_end_in  = sweep_end_ff;
      oob_in        = oob_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = '0;
      mem_raddr     = '0;
      mem_wdata     = ates_pkg::CH_SPACE;
      enq           = 1'b0;
      enq_word      = '0;

      b         = req_ch.byte_in;
      spoil_now = spoiled_ff;
      num_sel   = (num_idx_ff == 2'd0) ? first_ff : second_ff;
      acc       = ({4'b0, num_sel} << 3) + ({4'b0, num_sel} << 1) + {8'b0, b[3:0]};
      num_sat   = (acc > 12'(ates_pkg::NUM_MAX)) ? ates_pkg::NUM_MAX : acc[7:0];
      n         = (first_ff != 8'd0) ? first_ff : 8'd1;
      sum       = '0;
      row_base  = ADDR_W'(line_ff) * COLS_A;

      unique case (state_ff)
         ates_pkg::ST_IDLE: begin
            if (req_accept && req_ch.cmd) begin
               // cell read: ram answers next cycle
               mem_re = 1'b1;
               oob_in = !((9'(req_ch.read_row) < ROWS_9) && (9'(req_ch.read_col) < COLS_9));
               if (!oob_in) begin
                  mem_raddr = ADDR_W'(req_ch.read_row) * COLS_A + ADDR_W'(req_ch.read_col);
               end
               state_in = ates_pkg::ST_READ;
            end else if (req_accept) begin
               if (b == ates_pkg::CH_ESC) begin
                  // a fresh sequence, also when one is open
                  in_esc_in  = 1'b1;
                  esc_cnt_in = '0;
                  first_in   = '0;
                  second_in  = '0;
                  num_idx_in = '0;
                  spoiled_in = 1'b0;
               end else if (!in_esc_ff) begin
                  priority if (b == ates_pkg::CH_CR) begin
                     col_in = '0;
                  end else if (b == ates_pkg::CH_LF) begin
                     if (line_ff != LAST_ROW) begin
                        line_in = line_ff + 1'b1;
                     end
                  end else if (b == ates_pkg::CH_BS) begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end
                  end else if (b == ates_pkg::CH_BEL) begin
                     col_in = col_ff;
                  end else if (col_ff < COLS_C) begin
                     mem_we    = 1'b1;
                     mem_waddr = row_base + ADDR_W'(col_ff);
                     mem_wdata = b;
                     col_in    = col_ff + 1'b1;
                  end else begin
                     // past the last column the byte is dropped
                     col_in = col_ff;
                  end
               end else if (esc_cnt_ff == '0) begin
                  // byte right after ESC: only '[' keeps the sequence open
                  esc_cnt_in = EC_W'(1);
                  if (b != ates_pkg::CH_LBRACKET) begin
                     if ((b == ates_pkg::CH_UPPER_M) && (line_ff != '0)) begin
                        line_in = line_ff - 1'b1;
                     end
                     in_esc_in  = 1'b0;
                     esc_cnt_in = '0;
                  end
               end else begin
                  if (esc_cnt_ff < STORE_FULL) begin
                     esc_cnt_in = esc_cnt_ff + 1'b1;
                  end else begin
                     spoil_now = 1'b1;
                  end
                  spoiled_in = spoil_now;
                  priority if ((b >= ates_pkg::CH_ZERO) && (b <= ates_pkg::CH_NINE)) begin
                     if (num_idx_ff == 2'd0) begin
                        first_in = num_sat;
                     end else if (num_idx_ff == 2'd1) begin
                        second_in = num_sat;
                     end
                  end else if (b == ates_pkg::CH_SEMI) begin
                     if (num_idx_ff != 2'd2) begin
                        num_idx_in = num_idx_ff + 1'b1;
                     end
                  end else if ((b >= ates_pkg::FINAL_LOW) && (b <= ates_pkg::FINAL_HIGH)) begin
                     in_esc_in  = 1'b0;
                     esc_cnt_in = '0;
                     if (!spoil_now) begin
                        unique case (b)
                           ates_pkg::CSI_POS, ates_pkg::CSI_POS_ALT: begin
                              col_in  = ((second_ff != 8'd0) && ({1'b0, second_ff} <= COLS_9))
                                        ? COL_W'(second_ff - 8'd1) : '0;
                              line_in = ((first_ff != 8'd0) && ({1'b0, first_ff} <= ROWS_9))
                                        ? ROW_W'(first_ff - 8'd1) : '0;
                           end
                           ates_pkg::CSI_CLEAR: begin
                              col_in        = '0;
                              line_in       = '0;
                              sweep_addr_in = '0;
                              sweep_end_in  = LAST_CELL;
                              state_in      = ates_pkg::ST_SWEEP;
                           end
                           ates_pkg::CSI_ERASE: begin
                              // nothing to erase once the cursor is past the edge
                              if (col_ff < COLS_C) begin
                                 sweep_addr_in = row_base + ADDR_W'(col_ff);
                                 sweep_end_in  = row_base + COLS_M1_A;
                                 state_in      = ates_pkg::ST_SWEEP;
                              end
                           end
                           ates_pkg::CSI_UP: begin
                              line_in = ({1'b0, n} <= 9'(line_ff))
                                        ? ROW_W'(9'(line_ff) - {1'b0, n}) : '0;
                           end
                           ates_pkg::CSI_DOWN: begin
                              sum     = 9'(line_ff) + {1'b0, n};
                              line_in = (sum >= ROWS_9) ? LAST_ROW : ROW_W'(sum);
                           end
                           ates_pkg::CSI_RIGHT: begin
                              sum    = 9'(col_ff) + {1'b0, n};
                              col_in = (sum >= COLS_9) ? LAST_COL : COL_W'(sum);
                           end
                           ates_pkg::CSI_LEFT: begin
                              col_in = ({1'b0, n} <= 9'(col_ff))
                                       ? COL_W'(9'(col_ff) - {1'b0, n}) : '0;
                           end
                           default: begin
                              col_in = col_ff;
                           end
                        endcase
                     end
                  end else begin
                     spoiled_in = 1'b1;
                  end
               end
               // a feed word is complete at once, sweeps run behind it
               enq                     = 1'b1;
               enq_word.cell_value     = '0;
               enq_word.column_now     = col_in;
               enq_word.row_now        = line_in;
               enq_word.escape_pending = in_esc_in;
            end
         end
         ates_pkg::ST_READ: begin
            enq                     = 1'b1;
            enq_word.cell_value     = oob_ff ? 8'd0 : rdata_ff;
            enq_word.column_now     = col_ff;
            enq_word.row_now        = line_ff;
            enq_word.escape_pending = in_esc_ff;
            state_in                = ates_pkg::ST_IDLE;
         end
         ates_pkg::ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = ates_pkg::CH_SPACE;
            if (sweep_addr_ff == sweep_end_ff) begin
               state_in = ates_pkg::ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ates_pkg::ST_IDLE;
         end
      endcase
   end

   // response queue update
   always_comb begin
      head_in   = head_ff;
      head_v_in = head_v_ff;
      tail_in   = tail_ff;
      tail_v_in = tail_v_ff;
      if (rsp_take) begin
         head_in   = tail_ff;
         head_v_in = tail_v_ff;
         tail_v_in = 1'b0;
      end
      if (enq) begin
         if (!head_v_in) begin
            head_in   = enq_word;
            head_v_in = 1'b1;
         end else begin
            tail_in   = enq_word;
            tail_v_in = 1'b1;
         end
      end
   end

   // queue never holds a tail without a head
   a_tail_needs_head: assert property (@(posedge clock) disable iff (reset)
      tail_v_ff |-> head_v_ff)
      else $error("response tail valid without head");

   // nothing is queued into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      enq |-> !(head_v_ff && tail_v_ff && !rsp_take))
      else $error("response queue overflow");

   // a read request enters the read state in the next cycle to take the ram's word
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.cmd) |=> (state_ff == ates_pkg::ST_READ))
      else $error("read request did not enter read state");

   // cursor stays on the screen, the column may sit just past the edge
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= COLS_C) && (line_ff <= LAST_ROW))
      else $error("cursor out of range");

   // a sweep never runs past its last cell
   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ates_pkg::ST_SWEEP) |-> (sweep_addr_ff <= sweep_end_ff))
      else $error("sweep address past end");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the text screen terminal: stimulus, prediction and word checks
module tb;

   // screen geometry and escape store, kept equal to the block's defaults
   localparam int ROWS  = 24;
   localparam int COLS  = 80;
   localparam int STORE = 63;
   localparam int CELLS = ROWS * COLS;

   // run shaping
   localparam int RANDOM_WORDS = 1150;   // rough size of the random part
   localparam int CALM_TAIL    = 150;    // last words go through with no idling
   localparam int QUIET_LIMIT  = 20000;  // watchdog limit, longer than a full screen sweep
   localparam int TAIL_CYCLES  = 64;     // settle time once nothing is due

   // final byte with no meaning to this terminal (select graphic rendition)
   localparam logic [7:0] SGR_FINAL = 8'h6d;

   typedef struct packed {
      logic       pause;      // marker: hold the sender until every reply is in
      logic       cmd;
      logic [7:0] byte_in;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } term_word_type;

   typedef struct packed {
      logic [7:0] cell_value;
      logic [6:0] column_now;
      logic [4:0] row_now;
      logic       escape_pending;
   } screen_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ates_req_if #(.ROW_W(5), .COL_W(7)) req_ch ();
   ates_rsp_if #(.ROW_W(5), .COL_W(7)) rsp_ch ();

   ansi_escape_text_screen #(
      .SCREEN_ROWS (ROWS),
      .SCREEN_COLS (COLS),
      .ESCAPE_STORE(STORE)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // terminal predictor: own copy of the screen, cursor and escape decoder
   // ---------------------------------------------------------------------
   logic [7:0] glyphs [0:CELLS-1];
   int         cur_col;
   int         cur_row;
   bit         seq_open;    // escape sequence being collected
   int         seq_len;     // bytes stored since ESC
   int         field_a;     // first numeric field
   int         field_b;     // second numeric field
   int         field_sel;   // which field digits go to, saturates at 2
   bit         seq_bad;     // sequence spoiled, its final does nothing

   // blank screen and cursor home, as after reset and on ESC [ J
   function automatic void wipe_screen();
      int k;
      for (k = 0; k < CELLS; k++) glyphs[k] = ates_pkg::CH_SPACE;
      cur_col = 0;
      cur_row = 0;
   endfunction

   // plain byte outside any escape sequence
   function automatic void put_glyph(logic [7:0] b);
      if (b == ates_pkg::CH_CR) begin
         cur_col = 0;
      end else if (b == ates_pkg::CH_LF) begin
         if (cur_row < ROWS - 1) cur_row++;
      end else if (b == ates_pkg::CH_BS) begin
         if (cur_col > 0) cur_col--;
      end else if (b != ates_pkg::CH_BEL && cur_col < COLS) begin
         // past the last column the byte is simply dropped
         glyphs[cur_row * COLS + cur_col] = b;
         cur_col++;
      end
   endfunction

   // final byte of an unspoiled control sequence
   function automatic void obey_csi(logic [7:0] fin);
      int n;
      int c;
      int r;
      int x;
      n = (field_a != 0) ? field_a : 1;
      case (fin)
         ates_pkg::CSI_POS, ates_pkg::CSI_POS_ALT: begin
            // 1-based, anything off the screen (or absent) lands on 0
            c = field_b - 1;
            r = field_a - 1;
            cur_col = (c >= 0 && c < COLS) ? c : 0;
            cur_row = (r >= 0 && r < ROWS) ? r : 0;
         end
         ates_pkg::CSI_CLEAR: wipe_screen();
         ates_pkg::CSI_ERASE: begin
            for (x = cur_col; x < COLS; x++) glyphs[cur_row * COLS + x] = ates_pkg::CH_SPACE;
         end
         ates_pkg::CSI_UP:    cur_row = (cur_row - n < 0) ? 0 : cur_row - n;
         ates_pkg::CSI_DOWN:  cur_row = (cur_row + n > ROWS - 1) ? ROWS - 1 : cur_row + n;
         ates_pkg::CSI_RIGHT: cur_col = (cur_col + n > COLS - 1) ? COLS - 1 : cur_col + n;
         ates_pkg::CSI_LEFT:  cur_col = (cur_col - n < 0) ? 0 : cur_col - n;
         default: ;
      endcase
   endfunction

   // one output byte through the escape decoder
   function automatic void take_byte(logic [7:0] b);
      int v;
      if (b == ates_pkg::CH_ESC) begin
         // always opens a fresh sequence, even in the middle of one
         seq_open  = 1'b1;
         seq_len   = 0;
         field_a   = 0;
         field_b   = 0;
         field_sel = 0;
         seq_bad   = 1'b0;
      end else if (!seq_open) begin
         put_glyph(b);
      end else if (seq_len == 0) begin
         seq_len = 1;
         if (b != ates_pkg::CH_LBRACKET) begin
            // ESC M is reverse line feed, any other byte just ends it
            if (b == ates_pkg::CH_UPPER_M && cur_row > 0) cur_row--;
            seq_open = 1'b0;
            seq_len  = 0;
         end
      end else begin
         if (seq_len < STORE) seq_len++;
         else seq_bad = 1'b1;
         if (b >= ates_pkg::CH_ZERO && b <= ates_pkg::CH_NINE) begin
            if (field_sel == 0) begin
               v = field_a * 10 + int'(b - ates_pkg::CH_ZERO);
               field_a = (v > int'(ates_pkg::NUM_MAX)) ? int'(ates_pkg::NUM_MAX) : v;
            end else if (field_sel == 1) begin
               v = field_b * 10 + int'(b - ates_pkg::CH_ZERO);
               field_b = (v > int'(ates_pkg::NUM_MAX)) ? int'(ates_pkg::NUM_MAX) : v;
            end
         end else if (b == ates_pkg::CH_SEMI) begin
            if (field_sel < 2) field_sel++;
         end else if (b >= ates_pkg::FINAL_LOW && b <= ates_pkg::FINAL_HIGH) begin
            if (!seq_bad) obey_csi(b);
            seq_open = 1'b0;
            seq_len  = 0;
         end else begin
            seq_bad = 1'b1;
         end
      end
   endfunction

   // expected reply word for one accepted request word
   function automatic screen_reply_type terminal_step(term_word_type w);
      screen_reply_type r;
      r = '0;
      if (w.cmd == 1'b0) begin
         take_byte(w.byte_in);
      end else if (int'(w.read_row) < ROWS && int'(w.read_col) < COLS) begin
         r.cell_value = glyphs[int'(w.read_row) * COLS + int'(w.read_col)];
      end
      r.column_now     = 7'(cur_col);
      r.row_now        = 5'(cur_row);
      r.escape_pending = seq_open;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus store
   // ---------------------------------------------------------------------
   term_word_type    byte_stream [$];   // words waiting to be sent
   screen_reply_type replies_due [$];   // predicted words, oldest first

   function automatic void add_byte(logic [7:0] b);
      term_word_type w;
      w.pause    = 1'b0;
      w.cmd      = 1'b0;
      w.byte_in  = b;
      w.read_row = 5'($urandom_range(0, 31));
      w.read_col = 7'($urandom_range(0, 127));
      byte_stream.push_back(w);
   endfunction

   function automatic void add_read(int r, int c);
      term_word_type w;
      w.pause    = 1'b0;
      w.cmd      = 1'b1;
      w.byte_in  = 8'($urandom_range(0, 255));
      w.read_row = 5'(r);
      w.read_col = 7'(c);
      byte_stream.push_back(w);
   endfunction

   function automatic void add_pause();
      term_word_type w;
      w       = '0;
      w.pause = 1'b1;
      byte_stream.push_back(w);
   endfunction

   function automatic void add_string(string s);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   // numeric field: mostly small, some near the right edge, some that saturate,
   // some left out altogether, now and then with a leading zero
   function automatic void add_field();
      int kind;
      int v;
      kind = $urandom_range(0, 9);
      if (kind == 0) return;
      if (kind == 1) v = $urandom_range(256, 99999);
      else if (kind <= 3) v = $urandom_range(70, 85);
      else v = $urandom_range(0, 25);
      if ($urandom_range(0, 7) == 0) add_byte(ates_pkg::CH_ZERO);
      add_string($sformatf("%0d", v));
   endfunction

   // a byte that spoils a control sequence: no digit, separator, final or ESC
   function automatic logic [7:0] spoiler();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while ((b >= ates_pkg::CH_ZERO && b <= ates_pkg::CH_NINE) ||
                 b == ates_pkg::CH_SEMI || b == ates_pkg::CH_ESC ||
                 (b >= ates_pkg::FINAL_LOW && b <= ates_pkg::FINAL_HIGH));
      return b;
   endfunction

   // ---------------------------------------------------------------------
   // driver: new word at the falling edge once the previous one is taken
   // ---------------------------------------------------------------------
   logic req_taken = 1'b0;   // handshake seen at the last rising edge
   int   send_gap  = 0;
   int   stall_left = 0;
   int   quiet     = 0;
   int   faults    = 0;
   bit   timed_out = 1'b0;

   always @(negedge clock) begin : word_driver
      term_word_type w;
      logic          go;
      w  = '0;
      go = 1'b0;
      // a word still waiting for ready is held as it is
      if (!reset && !(req_ch.valid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
         end else if (byte_stream.size() > 0) begin
            if (byte_stream[0].pause) begin
               // drain point: wait for every reply before going on
               if (replies_due.size() == 0) byte_stream.delete(0);
            end else begin
               w  = byte_stream.pop_front();
               go = 1'b1;
               if (byte_stream.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 16);
            end
         end
         req_ch.valid <= go;
         if (go) begin
            req_ch.cmd      <= w.cmd;
            req_ch.byte_in  <= w.byte_in;
            req_ch.read_row <= w.read_row;
            req_ch.read_col <= w.read_col;
         end
      end
   end

   // receiver pacing: bursts of back-pressure, none near the end
   always @(negedge clock) begin : reply_pacing
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!reset && byte_stream.size() >= CALM_TAIL &&
                   $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: predict on request handshakes, check on reply handshakes
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
         faults++;
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : word_monitor
      screen_reply_type want;
      term_word_type    seen;
      if (reset) begin
         quiet = 0;
         req_taken <= 1'b0;
      end else begin
         // reply first: a word on rsp_ch now belongs to an earlier request
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (replies_due.size() == 0) begin
               faults++;
               $error("reply word arrived with nothing due");
            end else begin
               want = replies_due.pop_front();
               check_field("cell_value", want.cell_value, rsp_ch.cell_value);
               check_field("column_now", 8'(want.column_now), 8'(rsp_ch.column_now));
               check_field("row_now", 8'(want.row_now), 8'(rsp_ch.row_now));
               check_field("escape_pending", 8'(want.escape_pending),
                           8'(rsp_ch.escape_pending));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            seen.pause    = 1'b0;
            seen.cmd      = req_ch.cmd;
            seen.byte_in  = req_ch.byte_in;
            seen.read_row = req_ch.read_row;
            seen.read_col = req_ch.read_col;
            replies_due.push_back(terminal_step(seen));
         end
         req_taken <= req_ch.valid && req_ch.ready;

         // watchdog: any handshake on either side counts as progress
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) timed_out = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin : run_control
      int start_words;
      int pick;
      int len;
      int i;
      logic [7:0] fin;

      // every input known from time zero
      req_ch.valid    = 1'b0;
      req_ch.cmd      = 1'b0;
      req_ch.byte_in  = 8'h00;
      req_ch.read_row = 5'd0;
      req_ch.read_col = 7'd0;
      rsp_ch.ready    = 1'b0;

      // predictor starts from the reset state
      wipe_screen();
      seq_open  = 1'b0;
      seq_len   = 0;
      field_a   = 0;
      field_b   = 0;
      field_sel = 0;
      seq_bad   = 1'b0;

      // directed part
      add_read(31, 127);              // off the screen, every address bit set
      add_read(23, 79);               // last cell on the screen
      add_byte(8'hff);
      add_byte(ates_pkg::CH_BS);
      add_byte(ates_pkg::CH_CR);
      add_byte(ates_pkg::CH_LF);
      add_byte(ates_pkg::CH_BEL);
      add_byte(ates_pkg::CH_ESC);     // reverse line feed
      add_byte(ates_pkg::CH_UPPER_M);
      add_byte(ates_pkg::CH_ESC);     // row saturates at 255, so it goes to 0
      add_string("[999;2H");
      add_byte(ates_pkg::CH_ESC);     // erase to end of line
      add_string("[K");
      add_byte(ates_pkg::CH_ESC);     // ESC restarts, then a spoiled clear
      add_byte(ates_pkg::CH_ESC);
      add_string("[1!J");
      add_byte(ates_pkg::CH_ESC);     // real clear, a full sweep
      add_string("[J");
      add_pause();
      start_words = byte_stream.size();

      // random part: mostly well-formed text and sequences, some noise
      while (byte_stream.size() < start_words + RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         if (pick < 28) begin
            // text run, now and then long enough to run off the line
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 8);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
               else add_byte(8'($urandom_range(32, 126)));
            end
         end else if (pick < 38) begin
            case ($urandom_range(0, 3))
               0: add_byte(ates_pkg::CH_CR);
               1: add_byte(ates_pkg::CH_LF);
               2: add_byte(ates_pkg::CH_BS);
               default: add_byte(ates_pkg::CH_BEL);
            endcase
         end else if (pick < 52) begin
            // reads lean towards the top left, where text tends to land
            add_read(($urandom_range(0, 4) == 0) ? $urandom_range(24, 31) :
                     ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 23)),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(80, 127) :
                     ($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 79)));
         end else if (pick < 84) begin
            // well-formed control sequence with zero to three fields
            add_byte(ates_pkg::CH_ESC);
            add_byte(ates_pkg::CH_LBRACKET);
            len = $urandom_range(0, 3);
            for (i = 0; i < len; i++) begin
               if (i > 0) add_byte(ates_pkg::CH_SEMI);
               add_field();
            end
            case ($urandom_range(0, 11))
               0: fin = ates_pkg::CSI_UP;
               1: fin = ates_pkg::CSI_DOWN;
               2: fin = ates_pkg::CSI_RIGHT;
               3: fin = ates_pkg::CSI_LEFT;
               4, 5: fin = ates_pkg::CSI_POS;
               6: fin = ates_pkg::CSI_POS_ALT;
               7, 8: fin = ates_pkg::CSI_ERASE;
               9: fin = SGR_FINAL;
               10: fin = 8'($urandom_range(int'(ates_pkg::FINAL_LOW),
                                           int'(ates_pkg::FINAL_HIGH)));
               default: fin = ($urandom_range(0, 3) == 0) ? ates_pkg::CSI_CLEAR
                                                            : ates_pkg::CSI_POS;
            endcase
            add_byte(fin);
         end else if (pick < 89) begin
            // ESC and a second byte: reverse line feed or something ignored
            add_byte(ates_pkg::CH_ESC);
            if ($urandom_range(0, 9) < 6) add_byte(ates_pkg::CH_UPPER_M);
            else add_byte(8'($urandom_range(0, 255)));
         end else if (pick < 95) begin
            // spoiled sequence: must leave screen and cursor alone
            add_byte(ates_pkg::CH_ESC);
            add_byte(ates_pkg::CH_LBRACKET);
            add_field();
            add_byte(spoiler());
            if ($urandom_range(0, 1)) begin
               add_byte(ates_pkg::CH_SEMI);
               add_field();
            end
            case ($urandom_range(0, 3))
               0: add_byte(ates_pkg::CSI_POS);
               1: add_byte(ates_pkg::CSI_DOWN);
               2: add_byte(ates_pkg::CSI_ERASE);
               default: add_byte(ates_pkg::CSI_CLEAR);
            endcase
         end else if (pick < 97 && $urandom_range(0, 2) == 0) begin
            // long sequence straddling the store limit
            add_byte(ates_pkg::CH_ESC);
            add_byte(ates_pkg::CH_LBRACKET);
            len = $urandom_range(59, 64);
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 6) == 0) add_byte(ates_pkg::CH_SEMI);
               else add_byte(8'($urandom_range(int'(ates_pkg::CH_ZERO),
                                               int'(ates_pkg::CH_NINE))));
            end
            case ($urandom_range(0, 2))
               0: add_byte(ates_pkg::CSI_RIGHT);
               1: add_byte(ates_pkg::CSI_POS);
               default: add_byte(ates_pkg::CSI_DOWN);
            endcase
         end else begin
            add_byte(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 299) == 0) add_pause();
      end

      // synchronous reset, then the block runs its clearing pass
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // everything sent and answered, or the watchdog fired
      while (!timed_out &&
             !(byte_stream.size() == 0 && !req_ch.valid && replies_due.size() == 0))
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (!timed_out && faults == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
sv/ates_pkg.sv
sv/ates_if.sv
sv/ansi_escape_text_screen.sv
tb/sv/tb.sv
